// ----- hdl/tal_pkg.sv -----
`timescale 1ns / 1ps
package tal_pkg;

	localparam int INTEGRATOR_LIMIT = 4096;
	localparam int NOMINAL_THRUST = 160;
	localparam int THRUST_FLOOR = 32;
	localparam bit THRUST_SCHEDULING = 1'b1;

	// numerator of the thrust schedule division
	localparam int NUM_W = 59;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] REG_ANGLE_GAIN_X = 3'd0;
	localparam logic [2:0] REG_RATE_GAIN_X = 3'd1;
	localparam logic [2:0] REG_INTEGRAL_GAIN_X = 3'd2;
	localparam logic [2:0] REG_ANGLE_GAIN_Y = 3'd3;
	localparam logic [2:0] REG_RATE_GAIN_Y = 3'd4;
	localparam logic [2:0] REG_INTEGRAL_GAIN_Y = 3'd5;
	localparam logic [2:0] REG_GAIN_SCALE = 3'd6;
	localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd7;

	typedef enum logic [3:0] {
		LS_IDLE, LS_MA, LS_MR, LS_MI, LS_MD, LS_MAG, LS_SL, LS_SH, LS_S2,
		LS_NL, LS_NH, LS_DIV, LS_WAIT, LS_FIN, LS_DONE
	} lane_state_t;

	// one axis request handed to a lane
	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] rate;
		logic [23:0] angle_gain;
		logic [23:0] rate_gain;
		logic [23:0] integral_gain;
		logic [15:0] scale;
		logic [14:0] limit;
		logic [15:0] tick;
		logic [15:0] den;
		logic [14:0] den_half;
		logic enable;
		logic servo_sat;
		logic clear;
	} lane_cmd_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [23:0] raw;
		logic signed [23:0] integ;
	} lane_res_t;

endpackage

// ----- hdl/tal_div.sv -----
`timescale 1ns / 1ps
module tal_div import tal_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NUM_W-1:0] num,
	input  logic [15:0] den,
	output logic done,
	output logic [NUM_W-1:0] quo
);
	logic [15:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [16:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

// ----- hdl/tal_lane.sv -----
`timescale 1ns / 1ps
module tal_lane import tal_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  lane_cmd_t cmd,
	input  logic ack,
	output logic idle,
	output logic done,
	output lane_res_t res
);
	lane_state_t state_q, state_d;
	lane_cmd_t cmd_q;
	logic integrating_q;
	logic signed [23:0] integ_q;
	logic signed [24:0] mul_a, mul_b;
	logic signed [49:0] prod_q, acc_q;
	logic signed [31:0] p_q;
	logic neg_q;
	logic [37:0] m1_q;
	logic [41:0] m2_q;
	logic [49:0] t_q;
	logic [NUM_W-1:0] q_q;
	lane_res_t res_q;
	logic [59:0] part_sum;
	logic [49:0] abs_acc;
	logic [NUM_W-1:0] num;
	logic div_done;
	logic [NUM_W-1:0] div_q;
	logic [59:0] m3;
	logic signed [24:0] raw;
	logic signed [24:0] lim_s;
	logic [31:0] abs_p;
	logic signed [16:0] inc;
	logic signed [24:0] sum_i;
	logic sat, deepen;

	// partial products are recombined as low + high << 24
	assign part_sum = 60'(t_q) + (60'(prod_q) << 24);
	assign abs_acc = acc_q[49] ? 50'(-acc_q) : 50'(acc_q);
	assign num = NUM_W'(part_sum + 60'(cmd_q.den_half));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			LS_MA: begin mul_a = {1'b0, cmd_q.angle_gain}; mul_b = 25'(cmd_q.angle); end
			LS_MR: begin mul_a = {1'b0, cmd_q.rate_gain}; mul_b = 25'(cmd_q.rate); end
			LS_MI: begin mul_a = {1'b0, cmd_q.integral_gain}; mul_b = 25'(integ_q); end
			LS_MD: begin mul_a = 25'(cmd_q.angle); mul_b = {9'b0, cmd_q.tick}; end
			LS_SL: begin mul_a = {1'b0, m1_q[23:0]}; mul_b = {9'b0, cmd_q.scale}; end
			LS_SH: begin mul_a = {11'b0, m1_q[37:24]}; mul_b = {9'b0, cmd_q.scale}; end
			LS_NL: begin mul_a = {1'b0, m2_q[23:0]}; mul_b = 25'(NOMINAL_THRUST); end
			LS_NH: begin mul_a = {7'b0, m2_q[41:24]}; mul_b = 25'(NOMINAL_THRUST); end
			default: ;
		endcase
	end

	tal_div u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == LS_DIV && THRUST_SCHEDULING),
		.num(num), .den(cmd_q.den), .done(div_done), .quo(div_q)
	);

	// final rounding, saturation, clamp and integrator update
	always_comb begin
		m3 = (60'(q_q) + 60'd8) >> 4;
		if (neg_q) raw = (m3 > 60'd8388607) ? 25'sd8388607 : 25'(m3);
		else raw = (m3 > 60'd8388608) ? -25'sd8388608 : -25'(m3);
		lim_s = {10'b0, cmd_q.limit};
		abs_p = p_q[31] ? 32'(-p_q) : 32'(p_q);
		inc = 17'((33'(abs_p) + 33'd32768) >> 16);
		if (p_q[31]) inc = -inc;
		sat = raw >= lim_s || raw <= -lim_s || cmd_q.servo_sat;
		deepen = (inc > 0 && raw < 0) || (inc < 0 && raw > 0);
		sum_i = 25'(integ_q) + 25'(inc);
		if (sum_i > 25'(INTEGRATOR_LIMIT)) sum_i = 25'(INTEGRATOR_LIMIT);
		else if (sum_i < -25'(INTEGRATOR_LIMIT)) sum_i = -25'(INTEGRATOR_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= LS_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LS_IDLE: if (start) state_d = LS_MA;
			LS_MA: state_d = LS_MR;
			LS_MR: state_d = LS_MI;
			LS_MI: state_d = LS_MD;
			LS_MD: state_d = LS_MAG;
			LS_MAG: state_d = LS_SL;
			LS_SL: state_d = LS_SH;
			LS_SH: state_d = LS_S2;
			LS_S2: state_d = LS_NL;
			LS_NL: state_d = LS_NH;
			LS_NH: state_d = LS_DIV;
			LS_DIV: state_d = THRUST_SCHEDULING ? LS_WAIT : LS_FIN;
			LS_WAIT: if (div_done) state_d = LS_FIN;
			LS_FIN: state_d = LS_DONE;
			LS_DONE: if (ack) state_d = LS_IDLE;
			default: state_d = LS_IDLE;
		endcase
	end

	// integrator store: zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (state_q == LS_IDLE && start) begin
			if (cmd.clear || !(cmd.enable && cmd.integral_gain != '0)) integ_q <= '0;
		end else if (state_q == LS_FIN && integrating_q && !(sat && deepen)) begin
			integ_q <= 24'(sum_i);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			LS_IDLE: begin
				cmd_q <= cmd;
				integrating_q <= cmd.enable && cmd.integral_gain != '0;
			end
			LS_MR: acc_q <= prod_q;
			LS_MI: acc_q <= acc_q + prod_q;
			LS_MD: acc_q <= acc_q + prod_q;
			LS_MAG: begin
				p_q <= prod_q[31:0];
				neg_q <= acc_q[49];
				m1_q <= 38'((51'(abs_acc) + 51'd2048) >> 12);
			end
			LS_SH: t_q <= prod_q;
			LS_S2: m2_q <= 42'((part_sum + 60'd2048) >> 12);
			LS_NH: t_q <= prod_q;
			LS_DIV: q_q <= NUM_W'(m2_q);
			LS_WAIT: if (div_done) q_q <= div_q;
			LS_FIN: begin
				res_q.raw <= 24'(raw);
				res_q.drive <= (raw > lim_s) ? 16'(lim_s) :
					((raw < -lim_s) ? 16'(-lim_s) : 16'(raw));
				res_q.integ <= (integrating_q && !(sat && deepen)) ? 24'(sum_i) : integ_q;
			end
			default: ;
		endcase
	end

	assign idle = state_q == LS_IDLE;
	assign done = state_q == LS_DONE;
	assign res = res_q;
endmodule

// ----- hdl/two_axis_lqr_integral_antiwindup.sv -----
`timescale 1ns / 1ps
// From input request to output request valid, a request passes 11 lane steps
// (three gain products, tick product, magnitude, scale and thrust products), the
// 59-step bit-serial thrust divider, final round/clamp and merge.
// A new request is taken only when both lanes are idle; it can be taken while the
// previous result still waits in the output register.
// Reset (arst_n low, async): gains zero, gain_scale 1.0, output_limit 0.5 rad,
// integrators zero, no result pending.
module two_axis_lqr_integral_antiwindup import tal_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// angle_x, angle_rate_x, angle_y, angle_rate_y, integrate_enable,
	// servo_saturated_x, servo_saturated_y, thrust, tick_length,
	// clear_integrators, zero pad
	input  logic [103:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// drive_x, drive_y, raw_drive_x, raw_drive_y, integral_x, integral_y
	output logic [127:0] m_tdata,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [23:0] cfg_data
);
	logic [23:0] angle_gain_q [2];
	logic [23:0] rate_gain_q [2];
	logic [23:0] integral_gain_q [2];
	logic [15:0] gain_scale_q;
	logic [14:0] output_limit_q;
	logic out_valid_q;
	logic [127:0] out_data_q;
	logic [15:0] thrust, den;
	lane_cmd_t cmd_x, cmd_y;
	lane_res_t res_x, res_y;
	logic idle_x, idle_y, done_x, done_y;
	logic start, ack;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_gain_q[0] <= '0; angle_gain_q[1] <= '0;
			rate_gain_q[0] <= '0; rate_gain_q[1] <= '0;
			integral_gain_q[0] <= '0; integral_gain_q[1] <= '0;
			gain_scale_q <= 16'd4096;
			output_limit_q <= 15'd2048;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_GAIN_X: angle_gain_q[0] <= cfg_data;
				REG_RATE_GAIN_X: rate_gain_q[0] <= cfg_data;
				REG_INTEGRAL_GAIN_X: integral_gain_q[0] <= cfg_data;
				REG_ANGLE_GAIN_Y: angle_gain_q[1] <= cfg_data;
				REG_RATE_GAIN_Y: rate_gain_q[1] <= cfg_data;
				REG_INTEGRAL_GAIN_Y: integral_gain_q[1] <= cfg_data;
				REG_GAIN_SCALE: gain_scale_q <= cfg_data[15:0];
				REG_OUTPUT_LIMIT: output_limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// thrust floor, shared by both lanes; a zero divisor becomes one
	assign thrust = s_tdata[82:67];
	always_comb begin
		den = (thrust < 16'(THRUST_FLOOR)) ? 16'(THRUST_FLOOR) : thrust;
		if (den == '0) den = 16'd1;
	end

	always_comb begin
		cmd_x.angle = s_tdata[15:0];
		cmd_x.rate = s_tdata[31:16];
		cmd_x.angle_gain = angle_gain_q[0];
		cmd_x.rate_gain = rate_gain_q[0];
		cmd_x.integral_gain = integral_gain_q[0];
		cmd_x.servo_sat = s_tdata[65];
		cmd_y = cmd_x;
		cmd_y.angle = s_tdata[47:32];
		cmd_y.rate = s_tdata[63:48];
		cmd_y.angle_gain = angle_gain_q[1];
		cmd_y.rate_gain = rate_gain_q[1];
		cmd_y.integral_gain = integral_gain_q[1];
		cmd_y.servo_sat = s_tdata[66];
		{cmd_x.scale, cmd_y.scale} = {2{gain_scale_q}};
		{cmd_x.limit, cmd_y.limit} = {2{output_limit_q}};
		{cmd_x.tick, cmd_y.tick} = {2{s_tdata[98:83]}};
		{cmd_x.den, cmd_y.den} = {2{den}};
		{cmd_x.den_half, cmd_y.den_half} = {2{den[15:1]}};
		{cmd_x.enable, cmd_y.enable} = {2{s_tdata[64]}};
		{cmd_x.clear, cmd_y.clear} = {2{s_tdata[99]}};
	end

	// both lanes run in lockstep, so one idle pair gates the input request
	assign s_tready = idle_x && idle_y;
	assign start = s_tvalid && s_tready;

	tal_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd_x), .ack(ack),
		.idle(idle_x), .done(done_x), .res(res_x)
	);
	tal_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd_y), .ack(ack),
		.idle(idle_y), .done(done_y), .res(res_y)
	);

	// merge: both lane results move into the output register together
	assign ack = done_x && done_y && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ack) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ack) out_data_q <= {res_y.integ, res_x.integ, res_y.raw, res_x.raw,
			res_y.drive, res_x.drive};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
endmodule

// ----- tb/tb_two_axis_lqr_integral_antiwindup.sv -----
`timescale 1ns / 1ps
module tb_two_axis_lqr_integral_antiwindup;
	import tal_pkg::*;

	localparam int LATENCY = 80;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// angle_x, angle_rate_x, angle_y, angle_rate_y, integrate_enable,
	// servo_saturated_x, servo_saturated_y, thrust, tick_length,
	// clear_integrators, zero pad
	logic [103:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// drive_x, drive_y, raw_drive_x, raw_drive_y, integral_x, integral_y
	logic [127:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;

	typedef struct {
		logic signed [15:0] angle[2];
		logic signed [15:0] rate[2];
		logic enable;
		logic sat[2];
		logic [15:0] thrust;
		logic [15:0] tick;
		logic clear;
	} tick_req_t;

	typedef struct {
		logic signed [15:0] drive[2];
		logic signed [23:0] raw[2];
		logic signed [23:0] integ[2];
	} drive_res_t;

	// predictor copy of registers and integrators
	logic [23:0] k_angle[2];
	logic [23:0] k_rate[2];
	logic [23:0] k_integ[2];
	logic [15:0] k_scale;
	logic [14:0] k_limit;
	longint integ_state[2];

	drive_res_t expected_drives[$];
	int errors;
	int results_seen;
	longint cycles;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_recv;

	two_axis_lqr_integral_antiwindup u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_two_axis_lqr_integral_antiwindup: errors");
			$finish;
		end
	end

	// round half away from zero on a magnitude
	function automatic longint unsigned rnd_shift(longint unsigned m, int sh);
		return (m + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic longint clamp_to(longint v, longint lim);
		return v < -lim ? -lim : (v > lim ? lim : v);
	endfunction

	// one control tick, updates integ_state
	function automatic drive_res_t predict_tick(tick_req_t r);
		drive_res_t res;
		longint unsigned thr, mag, pm;
		longint s, p, inc, raw, lim;
		bit running, s_neg, saturated, deepen;
		thr = r.thrust;
		lim = k_limit;
		if (r.clear) begin
			integ_state[0] = 0;
			integ_state[1] = 0;
		end
		if (thr < THRUST_FLOOR) thr = THRUST_FLOOR;
		if (thr == 0) thr = 1;
		for (int a = 0; a < 2; a++) begin
			running = r.enable && k_integ[a] != 0;
			if (!running) integ_state[a] = 0;
			s = longint'(k_angle[a]) * r.angle[a] + longint'(k_rate[a]) * r.rate[a]
				+ longint'(k_integ[a]) * integ_state[a];
			s_neg = s < 0;
			mag = s_neg ? -s : s;
			mag = rnd_shift(mag, 12);
			mag = rnd_shift(mag * k_scale, 12);
			if (THRUST_SCHEDULING)
				mag = (mag * NOMINAL_THRUST + thr / 2) / thr;
			mag = rnd_shift(mag, 4);
			if (s_neg) begin
				if (mag > 8388607) mag = 8388607;
				raw = mag;
			end else begin
				if (mag > 8388608) mag = 8388608;
				raw = -longint'(mag);
			end
			res.raw[a] = raw[23:0];
			res.drive[a] = 16'(clamp_to(raw, lim));
			if (running) begin
				p = longint'(r.angle[a]) * longint'(r.tick);
				pm = p < 0 ? -p : p;
				inc = rnd_shift(pm, 16);
				if (p < 0) inc = -inc;
				saturated = raw >= lim || raw <= -lim || r.sat[a];
				deepen = (inc > 0 && raw < 0) || (inc < 0 && raw > 0);
				if (!(saturated && deepen))
					integ_state[a] = clamp_to(integ_state[a] + inc, INTEGRATOR_LIMIT);
			end
			res.integ[a] = integ_state[a][23:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	// result checker
	always @(posedge clk) begin
		drive_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_drives.size() == 0) begin
				errors++;
				$display("unexpected result %0d", results_seen);
			end else begin
				want = expected_drives.pop_front();
				if ($signed(m_tdata[15:0]) != want.drive[0])
					report_mismatch("drive_x", $signed(m_tdata[15:0]), want.drive[0]);
				if ($signed(m_tdata[31:16]) != want.drive[1])
					report_mismatch("drive_y", $signed(m_tdata[31:16]), want.drive[1]);
				if ($signed(m_tdata[55:32]) != want.raw[0])
					report_mismatch("raw_drive_x", $signed(m_tdata[55:32]), want.raw[0]);
				if ($signed(m_tdata[79:56]) != want.raw[1])
					report_mismatch("raw_drive_y", $signed(m_tdata[79:56]), want.raw[1]);
				if ($signed(m_tdata[103:80]) != want.integ[0])
					report_mismatch("integral_x", $signed(m_tdata[103:80]), want.integ[0]);
				if ($signed(m_tdata[127:104]) != want.integ[1])
					report_mismatch("integral_y", $signed(m_tdata[127:104]), want.integ[1]);
			end
			results_seen++;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ANGLE_GAIN_X: k_angle[0] = val;
			REG_RATE_GAIN_X: k_rate[0] = val;
			REG_INTEGRAL_GAIN_X: k_integ[0] = val;
			REG_ANGLE_GAIN_Y: k_angle[1] = val;
			REG_RATE_GAIN_Y: k_rate[1] = val;
			REG_INTEGRAL_GAIN_Y: k_integ[1] = val;
			REG_GAIN_SCALE: k_scale = val[15:0];
			REG_OUTPUT_LIMIT: k_limit = val[14:0];
			default: ;
		endcase
	endtask

	// send one tick request; valid stays high across back-to-back requests
	task automatic send_tick(tick_req_t r);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, r.clear, r.tick, r.thrust, r.sat[1], r.sat[0], r.enable,
			r.rate[1], r.angle[1], r.rate[0], r.angle[0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_drives.push_back(predict_tick(r));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_drives.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic tick_req_t random_tick();
		tick_req_t r;
		for (int a = 0; a < 2; a++) begin
			// mostly small angles so integrators move without pinning
			r.angle[a] = ($urandom_range(3) == 0) ? 16'($urandom)
				: 16'($signed($urandom_range(4000)) - 2000);
			r.rate[a] = ($urandom_range(3) == 0) ? 16'($urandom)
				: 16'($signed($urandom_range(4000)) - 2000);
			r.sat[a] = ($urandom_range(4) == 0);
		end
		r.enable = ($urandom_range(7) != 0);
		r.thrust = ($urandom_range(5) == 0) ? 16'($urandom_range(40)) : 16'($urandom);
		r.tick = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
		r.clear = ($urandom_range(30) == 0);
		return r;
	endfunction

	task automatic random_gains(bit extremes);
		logic [23:0] g;
		for (int i = 0; i < 6; i++) begin
			g = extremes ? ($urandom_range(1) ? 24'hFFFFFF : 24'd0)
				: 24'($urandom_range(200000));
			if (!extremes && $urandom_range(4) == 0) g = 24'($urandom);
			write_reg(3'(i), g);
		end
		write_reg(REG_GAIN_SCALE, extremes ? ($urandom_range(1) ? 24'hFFFF : 24'd0)
			: 24'($urandom_range(8192)));
		write_reg(REG_OUTPUT_LIMIT, extremes ? ($urandom_range(1) ? 24'h7FFF : 24'd0)
			: 24'($urandom_range(8192)));
	endtask

	task automatic test_directed();
		tick_req_t r;
		write_reg(REG_ANGLE_GAIN_X, 24'h010000);
		write_reg(REG_RATE_GAIN_X, 24'h008000);
		write_reg(REG_INTEGRAL_GAIN_X, 24'h020000);
		write_reg(REG_ANGLE_GAIN_Y, 24'hFFFFFF);
		write_reg(REG_RATE_GAIN_Y, 24'hFFFFFF);
		write_reg(REG_INTEGRAL_GAIN_Y, 24'hFFFFFF);
		for (int k = 0; k < 20; k++) begin
			r.angle[0] = (k % 2) ? 16'sh7FFF : 16'sh8000;
			r.angle[1] = (k % 3 == 0) ? 16'sh0000 : ((k % 2) ? 16'sh8000 : 16'sh7FFF);
			r.rate[0] = (k % 4 < 2) ? 16'sh8000 : 16'sh7FFF;
			r.rate[1] = (k % 5 == 0) ? 16'sh0001 : 16'shFFFF;
			r.enable = (k % 7 != 3);
			r.sat[0] = k[0];
			r.sat[1] = k[1];
			// thrust zero, below floor, at floor, max
			r.thrust = (k % 4 == 0) ? 16'd0 : (k % 4 == 1) ? 16'd31
				: (k % 4 == 2) ? 16'd32 : 16'hFFFF;
			r.tick = (k % 3 == 0) ? 16'hFFFF : (k % 3 == 1) ? 16'd0 : 16'd1;
			r.clear = (k == 9 || k == 15);
			if (k == 12) begin
				drain();
				write_reg(REG_OUTPUT_LIMIT, 24'd0);
			end
			send_tick(r);
		end
		drain();
		write_reg(REG_OUTPUT_LIMIT, 24'h7FFF);
		write_reg(REG_GAIN_SCALE, 24'hFFFF);
		r = random_tick();
		send_tick(r);
		drain();
	endtask

	task automatic test_random_phase(int n, int idle, int stall, bit extremes);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		random_gains(extremes);
		for (int k = 0; k < n; k++) send_tick(random_tick());
		drain();
	endtask

	// receiver held off while the sender keeps offering, then sender waits
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_gains(1'b0);
		fork
			begin
				hold_recv = 1'b1;
				repeat (600) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int k = 0; k < 12; k++) send_tick(random_tick());
		join
		drain();
		for (int k = 0; k < 10; k++) begin
			send_tick(random_tick());
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		results_seen = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1'b0;
		k_angle = '{0, 0};
		k_rate = '{0, 0};
		k_integ = '{0, 0};
		k_scale = 16'd4096;
		k_limit = 15'd2048;
		integ_state = '{0, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(400, 0, 0, 1'b0);
		test_random_phase(400, 51, 0, 1'b0);
		test_random_phase(400, 0, 51, 1'b0);
		test_random_phase(400, 36, 36, 1'b0);
		test_random_phase(60, 0, 0, 1'b1);
		test_random_phase(60, 36, 36, 1'b1);
		test_backpressure();

		$display("covered %0d results: field extremes, thrust floor, zero limit,",
			results_seen);
		$display("clear/enable mixes, extreme gains, idle and stall phases");
		if (errors == 0) begin
			$display("tb_two_axis_lqr_integral_antiwindup: clean");
		end else begin
			$display("tb_two_axis_lqr_integral_antiwindup: errors");
		end
		$finish;
	end

endmodule
